FILE: src/fzm_pkg.sv
`timescale 1ns / 1ps
// fzm_pkg: shared types, constants and character helpers for the fuzzy match scorer
// no dependencies; imported by fzm_core and fuzzy_string_match_scorer_top

package fzm_pkg;

   localparam int QUERY_MAX = 32;
   localparam int QIDX_W    = $clog2(QUERY_MAX);
   localparam int QLEN_W    = $clog2(QUERY_MAX + 1);
   localparam int CAND_MAX  = 1024;
   localparam int POS_W     = $clog2(CAND_MAX + 1);
   localparam int START_W   = 10;
   localparam int CHAR_W    = 16;
   localparam int SCORE_W   = 16;
   localparam int DELTA_W   = 12;
   localparam int SUM_W     = SCORE_W + 2;

   // opcodes
   localparam logic [1:0] OP_QUERY_WR  = 2'd0;
   localparam logic [1:0] OP_CAND_CHAR = 2'd1;
   localparam logic [1:0] OP_CAND_LAST = 2'd2;
   localparam logic [1:0] OP_CAND_END  = 2'd3;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 6;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_MODE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CASE_SENSITIVE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUERY_LENGTH   = 2'd2;

   localparam logic MODE_SUBSEQ = 1'b0;
   localparam logic MODE_SUBSTR = 1'b1;

   // score terms
   localparam logic signed [DELTA_W-1:0] SC_START       = 12'sd8;
   localparam logic signed [DELTA_W-1:0] SC_BOUNDARY    = 12'sd10;
   localparam logic signed [DELTA_W-1:0] SC_ADJACENT    = 12'sd15;
   localparam logic signed [DELTA_W-1:0] SC_EXACT       = 12'sd2;
   localparam logic signed [DELTA_W-1:0] SC_LEADING     = -12'sd3;
   localparam logic signed [DELTA_W-1:0] SC_SUBSTR_BASE = 12'sd100;
   localparam logic signed [DELTA_W-1:0] SC_PER_CHAR    = 12'sd15;

   // separator characters, letter range bounds and case offset
   localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 16'h005F;
   localparam logic [CHAR_W-1:0] CH_DASH       = 16'h002D;
   localparam logic [CHAR_W-1:0] CH_SPACE      = 16'h0020;
   localparam logic [CHAR_W-1:0] CH_SLASH      = 16'h002F;
   localparam logic [CHAR_W-1:0] CH_BACKSLASH  = 16'h005C;
   localparam logic [CHAR_W-1:0] CH_DOT        = 16'h002E;
   localparam logic [CHAR_W-1:0] CH_UPPER_A    = 16'h0041;
   localparam logic [CHAR_W-1:0] CH_UPPER_Z    = 16'h005A;
   localparam logic [CHAR_W-1:0] CH_LOWER_A    = 16'h0061;
   localparam logic [CHAR_W-1:0] CH_LOWER_Z    = 16'h007A;
   localparam logic [CHAR_W-1:0] CASE_OFFSET   = 16'h0020;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [QIDX_W-1:0] query_position;
      logic [CHAR_W-1:0] char_code;
   } req_item_type;

   typedef struct packed {
      logic                      is_match;
      logic signed [SCORE_W-1:0] score;
      logic [START_W-1:0]        match_start;
   } rsp_item_type;

   typedef struct packed {
      logic              match_mode;
      logic              case_sensitive;
      logic [QLEN_W-1:0] qlen;
   } cfg_type;

   function automatic logic is_upper(input logic [CHAR_W-1:0] c);
      return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
   endfunction

   function automatic logic is_lower(input logic [CHAR_W-1:0] c);
      return (c >= CH_LOWER_A) && (c <= CH_LOWER_Z);
   endfunction

   function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                   input logic case_sens);
      return (!case_sens && is_upper(c)) ? c + CASE_OFFSET : c;
   endfunction

   function automatic logic is_boundary(input logic [CHAR_W-1:0] prev,
                                        input logic [CHAR_W-1:0] cur);
      logic sep;
      sep = (prev == CH_UNDERSCORE) || (prev == CH_DASH) || (prev == CH_SPACE) ||
            (prev == CH_SLASH) || (prev == CH_BACKSLASH) || (prev == CH_DOT);
      return sep || (is_lower(prev) && is_upper(cur));
   endfunction

   function automatic logic signed [SCORE_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(32767);
      lo = -SUM_W'(32768);
      if (v > hi) begin
         return SCORE_W'(hi);
      end else if (v < lo) begin
         return SCORE_W'(lo);
      end
      return v[SCORE_W-1:0];
   endfunction

endpackage

FILE: src/fzm_core.sv
`timescale 1ns / 1ps
// fzm_core: query store, candidate window and per-character scoring state
// depends on fzm_pkg

module fzm_core import fzm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   logic [CHAR_W-1:0] query_store_ff [QUERY_MAX];
   logic [CHAR_W-1:0] window_ff [QUERY_MAX];
   logic [CHAR_W-1:0] wn [QUERY_MAX+1];

   logic [QLEN_W-1:0]         qidx_ff, qidx_in;
   logic [POS_W-1:0]          cand_pos_ff, cand_pos_in;
   logic [START_W-1:0]        prev_pos_ff, prev_pos_in;
   logic                      have_prev_ff, have_prev_in;
   logic signed [SCORE_W-1:0] score_ff, score_in;
   logic [CHAR_W-1:0]         prev_char_ff, prev_char_in;
   logic                      found_ff, found_in;
   logic [START_W-1:0]        first_pos_ff, first_pos_in;

   logic                      is_char, take, done;
   logic [CHAR_W-1:0]         q_char;
   logic                      matched;
   logic [POS_W-1:0]          gap;
   logic signed [DELTA_W-1:0] delta;
   logic signed [SUM_W-1:0]   score_ext;
   logic [QIDX_W-1:0]         aidx [QUERY_MAX];
   logic [QUERY_MAX-1:0]      hit;
   logic                      all_eq;
   logic [POS_W-1:0]          sub_start;
   logic signed [DELTA_W-1:0] sub_score;
   logic                      sub_cond;
   logic [QLEN_W-1:0]         qlen_m1;

   assign is_char = (item.opcode == OP_CAND_CHAR) || (item.opcode == OP_CAND_LAST);
   assign take    = step && is_char && (cand_pos_ff < POS_W'(CAND_MAX));
   assign done    = step && ((item.opcode == OP_CAND_LAST) || (item.opcode == OP_CAND_END));
   assign qlen_m1 = cfg.qlen - QLEN_W'(1);

   // window as it stands after the new character shifts in
   always_comb begin
      wn[0] = item.char_code;
      for (int k = 1; k <= QUERY_MAX; k++) begin
         wn[k] = window_ff[k-1];
      end
   end

   // substring: query char i against the char qlen-1-i back from the newest
   always_comb begin
      for (int i = 0; i < QUERY_MAX; i++) begin
         aidx[i] = QIDX_W'(qlen_m1 - QLEN_W'(i));
         hit[i]  = (QLEN_W'(i) >= cfg.qlen) ||
                   (fold_char(query_store_ff[i], cfg.case_sensitive) ==
                    fold_char(wn[{1'b0, aidx[i]}], cfg.case_sensitive));
      end
      all_eq = &hit;
   end

   assign sub_cond  = (cfg.match_mode == MODE_SUBSTR) && !found_ff && (cfg.qlen != '0) &&
                      ((cand_pos_ff + POS_W'(1)) >= POS_W'(cfg.qlen));
   assign sub_start = cand_pos_ff + POS_W'(1) - POS_W'(cfg.qlen);

   always_comb begin
      sub_score = SC_SUBSTR_BASE + SC_PER_CHAR * $signed({{(DELTA_W-QLEN_W){1'b0}}, cfg.qlen});
      if (sub_start == '0) begin
         sub_score = sub_score + SC_START;
      end else begin
         if (is_boundary(wn[cfg.qlen], wn[{1'b0, qlen_m1[QIDX_W-1:0]}])) begin
            sub_score = sub_score + SC_BOUNDARY;
         end
         sub_score = sub_score - $signed({{(DELTA_W-POS_W){1'b0}}, sub_start});
      end
   end

   // subsequence: one query char against the incoming char
   assign q_char    = query_store_ff[qidx_ff[QIDX_W-1:0]];
   assign matched   = fold_char(q_char, cfg.case_sensitive) ==
                      fold_char(item.char_code, cfg.case_sensitive);
   assign gap       = cand_pos_ff - {1'b0, prev_pos_ff} - POS_W'(1);
   assign score_ext = {{(SUM_W-SCORE_W){score_ff[SCORE_W-1]}}, score_ff};

   always_comb begin
      delta = '0;
      if (cand_pos_ff == '0) begin
         delta = SC_START;
      end else if (is_boundary(prev_char_ff, item.char_code)) begin
         delta = SC_BOUNDARY;
      end
      if (have_prev_ff) begin
         if (cand_pos_ff == {1'b0, prev_pos_ff} + POS_W'(1)) begin
            delta = delta + SC_ADJACENT;
         end else begin
            delta = delta - $signed({{(DELTA_W-POS_W){1'b0}}, gap});
         end
      end
      if (q_char == item.char_code) begin
         delta = delta + SC_EXACT;
      end
   end

   always_comb begin
      qidx_in      = qidx_ff;
      cand_pos_in  = cand_pos_ff;
      prev_pos_in  = prev_pos_ff;
      have_prev_in = have_prev_ff;
      score_in     = score_ff;
      prev_char_in = prev_char_ff;
      found_in     = found_ff;
      first_pos_in = first_pos_ff;

      if (take) begin
         if (cfg.match_mode == MODE_SUBSEQ) begin
            if (qidx_ff < cfg.qlen) begin
               if (!matched) begin
                  if (!have_prev_ff) begin
                     score_in = sat16(score_ext + SUM_W'(SC_LEADING));
                  end
               end else begin
                  score_in     = sat16(score_ext + {{(SUM_W-DELTA_W){delta[DELTA_W-1]}}, delta});
                  prev_pos_in  = cand_pos_ff[START_W-1:0];
                  have_prev_in = 1'b1;
                  qidx_in      = qidx_ff + QLEN_W'(1);
                  if (!have_prev_ff) begin
                     first_pos_in = cand_pos_ff[START_W-1:0];
                  end
               end
            end
         end else if (sub_cond && all_eq) begin
            score_in     = {{(SCORE_W-DELTA_W){sub_score[DELTA_W-1]}}, sub_score};
            found_in     = 1'b1;
            first_pos_in = sub_start[START_W-1:0];
         end
         prev_char_in = item.char_code;
         cand_pos_in  = cand_pos_ff + POS_W'(1);
      end

      // result from the state after this character
      result = '0;
      if (cfg.qlen == '0) begin
         result.is_match = 1'b1;
      end else if (cfg.match_mode == MODE_SUBSEQ ? (qidx_in >= cfg.qlen) : found_in) begin
         result.is_match    = 1'b1;
         result.score       = score_in;
         result.match_start = first_pos_in;
      end

      if (done) begin
         qidx_in      = '0;
         cand_pos_in  = '0;
         prev_pos_in  = '0;
         have_prev_in = 1'b0;
         score_in     = '0;
         prev_char_in = '0;
         found_in     = 1'b0;
         first_pos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qidx_ff      <= '0;
         cand_pos_ff  <= '0;
         prev_pos_ff  <= '0;
         have_prev_ff <= 1'b0;
         score_ff     <= '0;
         prev_char_ff <= '0;
         found_ff     <= 1'b0;
         first_pos_ff <= '0;
      end else begin
         qidx_ff      <= qidx_in;
         cand_pos_ff  <= cand_pos_in;
         prev_pos_ff  <= prev_pos_in;
         have_prev_ff <= have_prev_in;
         score_ff     <= score_in;
         prev_char_ff <= prev_char_in;
         found_ff     <= found_in;
         first_pos_ff <= first_pos_in;
      end
   end

   // query store, undefined until written
   always_ff @(posedge clock) begin
      if (step && (item.opcode == OP_QUERY_WR)) begin
         query_store_ff[item.query_position] <= item.char_code;
      end
   end

   // candidate shift line, only positions already seen are ever compared
   always_ff @(posedge clock) begin
      if (take) begin
         window_ff[0] <= item.char_code;
         for (int k = 1; k < QUERY_MAX; k++) begin
            window_ff[k] <= window_ff[k-1];
         end
      end
   end

endmodule

FILE: src/fuzzy_string_match_scorer_top.sv
`timescale 1ns / 1ps
// fuzzy_string_match_scorer_top: handshake, input and result registers, config registers
// depends on fzm_pkg and fzm_core

// Scores a streamed candidate string against a stored query. Query characters are
// written with opcode 0, candidate characters follow one per transaction, and one
// result comes for each last-character or end-of-candidate transaction. The block
// takes one transaction per clock cycle unless stalled; each passes an input register
// and then the scoring logic into the result register. The only stall comes from a
// result still waiting on rsp_stall when another result-producing transaction is
// ready to score.
// Configuration registers are written through the csr_ port, which is always ready;
// write them only between candidates.

module fuzzy_string_match_scorer_top import fzm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_item,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_item,
   // configuration write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // config registers
   logic              match_mode_ff, match_mode_in;
   logic              case_sens_ff, case_sens_in;
   logic [QLEN_W-1:0] query_length_ff, query_length_in;
   cfg_type           cfg;

   // input register
   logic              s1_valid_ff, s1_valid_in;
   req_item_type      s1_item_ff, s1_item_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_item_ff, rsp_item_in;

   logic              accept;
   logic              has_result;
   logic              out_free;
   logic              advance;
   rsp_item_type      core_result;

   // lengths beyond the store act as a full store
   assign cfg.match_mode     = match_mode_ff;
   assign cfg.case_sensitive = case_sens_ff;
   assign cfg.qlen = (query_length_ff > QLEN_W'(QUERY_MAX)) ? QLEN_W'(QUERY_MAX)
                                                            : query_length_ff;

   assign csr_ready = 1'b1;

   always_comb begin
      match_mode_in   = match_mode_ff;
      case_sens_in    = case_sens_ff;
      query_length_in = query_length_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MATCH_MODE:     match_mode_in   = csr_wdata[0];
            CSR_CASE_SENSITIVE: case_sens_in    = csr_wdata[0];
            CSR_QUERY_LENGTH:   query_length_in = csr_wdata[QLEN_W-1:0];
            default:            ;
         endcase
      end
   end

   // only result-producing transactions wait for the result register
   assign has_result = (s1_item_ff.opcode == OP_CAND_LAST) ||
                       (s1_item_ff.opcode == OP_CAND_END);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = s1_valid_ff && (!has_result || out_free);
   assign req_stall  = s1_valid_ff && !advance;
   assign accept     = req_valid && !req_stall;

   always_comb begin
      s1_item_in  = accept ? req_item : s1_item_ff;
      s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   end

   always_comb begin
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance && has_result) begin
         rsp_item_in  = core_result;
         rsp_valid_in = 1'b1;
      end
   end

   fzm_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (s1_item_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         match_mode_ff   <= 1'b0;
         case_sens_ff    <= 1'b0;
         query_length_ff <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         match_mode_ff   <= match_mode_in;
         case_sens_ff    <= case_sens_in;
         query_length_ff <= query_length_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // a scored result always shows up on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      advance && has_result |=> rsp_valid)
      else $error("scored result did not reach the result register");

   // input side only backs up behind a blocked result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall && has_result)
      else $error("input stalled without a blocked result");

   // a miss carries no score and no start position
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.is_match || (rsp_item.score == '0 && rsp_item.match_start == '0))
      else $error("unmatched result with nonzero score or start");

endmodule
